// File: rtl/mhpq_pkg.sv
// Package with shared constants and types for the max heap priority queue core.
package mhpq_pkg;

  localparam int DEPTH_DEFAULT     = 32;
  localparam int KEY_WIDTH_DEFAULT = 32;
  localparam int CAP_WIDTH         = 6;
  localparam int POS_WIDTH         = 5;
  localparam int IN_KEY_WIDTH      = 32;
  localparam int CAP_RESET         = 32;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE_MAX = 3'd1,
    OP_REMOVE_AT = 3'd2,
    OP_APPEND = 3'd3,
    OP_BUILD = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL = 2'd2,
    ST_BAD_POS = 2'd3
  } status_t;

endpackage

// File: rtl/mhpq_store.sv
// Heap key memory with one write port and one registered read port.
module mhpq_store #(
  parameter int DEPTH = mhpq_pkg::DEPTH_DEFAULT,
  parameter int KEY_WIDTH = mhpq_pkg::KEY_WIDTH_DEFAULT,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [KEY_WIDTH-1:0] wr_data,
  input  logic [AW-1:0]        rd_addr,
  output logic [KEY_WIDTH-1:0] rd_data
);

  logic [KEY_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: rtl/max_heap_priority_queue_core.sv
// Top level of the max heap priority queue core: sequencer around a key memory.
// The core holds up to DEPTH signed keys as a binary max heap in one memory with a
// registered read, and it works on one item at a time. The walks keep a hole: a key
// that moves is held in a register, entries that pass it are written into the hole,
// and one final write puts the held key in place. Every read is registered before
// its data can be compared, so time grows with the tree levels walked. A full insert
// or append, an empty or out-of-range removal, an unused code and a build over fewer
// than two entries are answered straight from the idle state. Append, and insert
// into an empty heap, go straight to the write. Insert reads and compares each
// parent in turn, then makes the final write. A removal first fetches the removed
// key and the last entry in the states RM_RD, LAST_RD and LAST_WAIT. A removal from
// a non-root position then climbs like an insert and ends with a write. Every removal
// that leaves a hole then sifts down, reading the left and the right child of each
// level before comparing. A walk that runs off the tree stops at the child read, and
// the final write follows. Build loads each internal node in BUILD_RD and BUILD_WAIT
// and then runs that node's sift-down. A result waits in the output register and
// blocks the input; the next item can be taken from the cycle after the result is
// accepted. The capacity register may be written while idle; the effective capacity
// is the smaller of its value and DEPTH. The memory has no reset; only entries below
// the entry count are ever used.
module max_heap_priority_queue_core #(
  parameter int DEPTH = mhpq_pkg::DEPTH_DEFAULT,
  parameter int KEY_WIDTH = mhpq_pkg::KEY_WIDTH_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [2:0]                          operation,
  input  logic signed [mhpq_pkg::IN_KEY_WIDTH-1:0] key,
  input  logic [mhpq_pkg::POS_WIDTH-1:0]      position,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [mhpq_pkg::IN_KEY_WIDTH-1:0] removed_key,
  output logic [1:0]                          status,
  output logic [$clog2(DEPTH+1)-1:0]          entry_total,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mhpq_pkg::CAP_WIDTH-1:0]      cfg_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  // Index arithmetic is two bits wider than the count so 2*i+2 never wraps.
  localparam int IW = CW + 2;
  localparam int KW = mhpq_pkg::IN_KEY_WIDTH;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_RM_RD,
    S_LAST_RD,
    S_LAST_WAIT,
    S_DN_RDL,
    S_DN_RDR,
    S_DN_CMP,
    S_BUILD_RD,
    S_BUILD_WAIT,
    S_PUT
  } state_t;

  state_t state;
  logic [CW-1:0] count;
  logic [mhpq_pkg::CAP_WIDTH-1:0] capacity;
  logic [IW-1:0] at;
  logic [IW-1:0] base;
  logic [IW-1:0] build_i;
  logic building;
  logic sift_fix;
  logic [KEY_WIDTH-1:0] moving;
  logic [KEY_WIDTH-1:0] left_key;
  logic [KEY_WIDTH-1:0] down_key;

  logic wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [KEY_WIDTH-1:0] wr_data, rd_data;

  mhpq_store #(.DEPTH(DEPTH), .KEY_WIDTH(KEY_WIDTH)) u_store (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  logic [IW-1:0] parent_idx, kid_l, kid_r;
  logic [CW-1:0] cap_eff;
  logic [KEY_WIDTH-1:0] key_fit;
  logic kid_r_valid, pick_r;
  logic [KEY_WIDTH-1:0] big_kid;
  logic [IW-1:0] big_idx;

  always_comb begin
    parent_idx = (at - IW'(1)) >> 1;
    kid_l = {at[IW-2:0], 1'b1};
    kid_r = kid_l + IW'(1);
    cap_eff = (32'(capacity) < 32'(DEPTH)) ? CW'(capacity) : CW'(DEPTH);
    key_fit = KEY_WIDTH'(64'(signed'(key)));
    kid_r_valid = kid_r < IW'(count);
    pick_r = kid_r_valid && ($signed(left_key) < $signed(rd_data));
    big_kid = pick_r ? rd_data : left_key;
    big_idx = pick_r ? kid_r : kid_l;
  end

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign cfg_ready = 1'b1;
  assign entry_total = count;

  // Memory read address and write port are steered by the sequencer. Read data is
  // used only after states that do not write, so no write collides with a read in use.
  always_comb begin
    wr_en = 1'b0;
    wr_addr = at[AW-1:0];
    wr_data = moving;
    unique case (state)
      S_UP_RD: rd_addr = parent_idx[AW-1:0];
      S_LAST_RD: rd_addr = AW'(count);
      S_DN_RDL: rd_addr = kid_l[AW-1:0];
      S_DN_RDR: rd_addr = kid_r[AW-1:0];
      S_BUILD_RD: rd_addr = build_i[AW-1:0];
      default: rd_addr = at[AW-1:0];
    endcase
    unique case (state)
      S_UP_CMP: begin
        // A smaller parent moves down into the hole.
        if ($signed(rd_data) < $signed(moving)) begin
          wr_en = 1'b1;
          wr_data = rd_data;
        end
      end
      S_DN_CMP: begin
        // The larger child moves up into the hole.
        if ($signed(moving) < $signed(big_kid)) begin
          wr_en = 1'b1;
          wr_data = big_kid;
        end
      end
      S_PUT: wr_en = 1'b1;
      default: wr_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      capacity <= mhpq_pkg::CAP_WIDTH'(mhpq_pkg::CAP_RESET);
      out_valid <= 1'b0;
      building <= 1'b0;
      sift_fix <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            removed_key <= '0;
            status <= mhpq_pkg::ST_OK;
            unique case (operation)
              mhpq_pkg::OP_INSERT, mhpq_pkg::OP_APPEND: begin
                if (count >= cap_eff) begin
                  status <= mhpq_pkg::ST_FULL;
                  out_valid <= 1'b1;
                end else begin
                  // The new key starts in a hole at the first free entry.
                  at <= IW'(count);
                  base <= IW'(count);
                  moving <= key_fit;
                  count <= count + CW'(1);
                  if (operation == mhpq_pkg::OP_INSERT && count != '0) begin
                    state <= S_UP_RD;
                  end else begin
                    state <= S_PUT;
                  end
                end
              end
              mhpq_pkg::OP_REMOVE_MAX, mhpq_pkg::OP_REMOVE_AT: begin
                if (count == '0) begin
                  status <= mhpq_pkg::ST_EMPTY;
                  out_valid <= 1'b1;
                end else if (operation == mhpq_pkg::OP_REMOVE_AT &&
                             IW'(position) >= IW'(count)) begin
                  status <= mhpq_pkg::ST_BAD_POS;
                  out_valid <= 1'b1;
                end else begin
                  at <= (operation == mhpq_pkg::OP_REMOVE_AT) ? IW'(position) : '0;
                  base <= (operation == mhpq_pkg::OP_REMOVE_AT) ? IW'(position) : '0;
                  count <= count - CW'(1);
                  state <= S_RM_RD;
                end
              end
              mhpq_pkg::OP_BUILD: begin
                if (count < CW'(2)) begin
                  out_valid <= 1'b1;
                end else begin
                  build_i <= IW'(count >> 1) - IW'(1);
                  building <= 1'b1;
                  state <= S_BUILD_RD;
                end
              end
              default: out_valid <= 1'b1;
            endcase
          end
        end
        // Sift up: compare with the parent; either pull it down or stop.
        S_UP_RD: state <= S_UP_CMP;
        S_UP_CMP: begin
          if ($signed(rd_data) < $signed(moving)) begin
            // The parent that lands in the starting slot is what a removal
            // later sifts down from there.
            if (at == base) begin
              down_key <= rd_data;
            end
            at <= parent_idx;
            state <= (parent_idx == '0) ? S_PUT : S_UP_RD;
          end else begin
            state <= S_PUT;
          end
        end
        // Removal: fetch the hole's key (result) then the last entry.
        S_RM_RD: state <= S_LAST_RD;
        S_LAST_RD: begin
          removed_key <= KW'(64'(rd_data));
          state <= S_LAST_WAIT;
        end
        S_LAST_WAIT: begin
          moving <= rd_data;
          down_key <= rd_data;
          if (at < IW'(count)) begin
            // The last entry fills the hole; it may have to climb first and
            // the slot is then sifted down in any case.
            if (at != '0) begin
              sift_fix <= 1'b1;
              state <= S_UP_RD;
            end else begin
              state <= S_DN_RDL;
            end
          end else begin
            state <= S_IDLE;
            out_valid <= 1'b1;
          end
        end
        // Sift down: read left then right child, write the larger into the hole if it beats the held key.
        S_DN_RDL: begin
          if (kid_l < IW'(count)) begin
            state <= S_DN_RDR;
          end else begin
            state <= S_PUT;
          end
        end
        S_DN_RDR: begin
          left_key <= rd_data;
          state <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if ($signed(moving) < $signed(big_kid)) begin
            at <= big_idx;
            state <= S_DN_RDL;
          end else begin
            state <= S_PUT;
          end
        end
        S_BUILD_RD: begin
          at <= build_i;
          state <= S_BUILD_WAIT;
        end
        S_BUILD_WAIT: begin
          moving <= rd_data;
          state <= S_DN_RDL;
        end
        // The held key goes into the hole; then the walk ends or the next one starts.
        S_PUT: begin
          if (sift_fix) begin
            sift_fix <= 1'b0;
            at <= base;
            moving <= down_key;
            state <= S_DN_RDL;
          end else if (building && build_i != '0) begin
            build_i <= build_i - IW'(1);
            state <= S_BUILD_RD;
          end else begin
            building <= 1'b0;
            state <= S_IDLE;
            out_valid <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) in_valid && in_ready |=> !in_ready)
    else $error("core accepted an item while busy");
  assert property (@(posedge clk) disable iff (rst) out_valid |-> state == S_IDLE)
    else $error("result shown while a sift was running");
  assert property (@(posedge clk) disable iff (rst) entry_total <= CW'(DEPTH))
    else $error("entry count exceeds depth");
  assert property (@(posedge clk) disable iff (rst) out_valid && !out_ready |=>
    out_valid && $stable(removed_key) && $stable(status) && $stable(entry_total))
    else $error("result changed while stalled");

endmodule
